### rtl/wsf_pkg.sv
// shared types, codes and rate table for the wifi signal field parser
// no dependencies; used by every stage module and the checker
`default_nettype none
package wsf_pkg;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_PARITY = 2'd1;
	localparam logic [1:0] ST_RATE   = 2'd2;

	// rate field codes, bit 0 of the field is the lsb
	localparam logic [3:0] RATE_6M  = 4'd11;
	localparam logic [3:0] RATE_9M  = 4'd15;
	localparam logic [3:0] RATE_12M = 4'd10;
	localparam logic [3:0] RATE_18M = 4'd14;
	localparam logic [3:0] RATE_24M = 4'd9;
	localparam logic [3:0] RATE_36M = 4'd13;
	localparam logic [3:0] RATE_48M = 4'd8;
	localparam logic [3:0] RATE_54M = 4'd12;

	// service plus tail bits
	localparam logic [15:0] SERVICE_TAIL_BITS = 16'd22;

	// reciprocal scale: 2^RECIP_SHIFT / odd divisor
	localparam int RECIP_SHIFT = 16;
	localparam logic [14:0] RECIP_3  = 15'((1 << RECIP_SHIFT) / 3);
	localparam logic [14:0] RECIP_9  = 15'((1 << RECIP_SHIFT) / 9);
	localparam logic [14:0] RECIP_27 = 15'((1 << RECIP_SHIFT) / 27);

	// bits per symbol = odd * 2^shift
	typedef struct packed {
		logic        known;
		logic [2:0]  encoding;
		logic [1:0]  modulation;
		logic [7:0]  per_symbol;
		logic [2:0]  shift;
		logic [4:0]  odd;
		logic [14:0] recip;
	} rate_info_t;

	// stage 1 word: header decoded, dividend reduced by the power of two
	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  encoding;
		logic [1:0]  modulation;
		logic [11:0] length;
		logic [13:0] dividend;
		logic [4:0]  odd;
		logic [14:0] recip;
	} s1_word_t;

	// stage 2 word: quotient estimate, low by at most one
	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  encoding;
		logic [1:0]  modulation;
		logic [11:0] length;
		logic [13:0] dividend;
		logic [4:0]  odd;
		logic [10:0] quot_est;
	} s2_word_t;

	function automatic rate_info_t rate_lookup(input logic [3:0] code);
		rate_info_t r;
		r = '{known: 1'b1, encoding: 3'd0, modulation: 2'd0, per_symbol: 8'd24,
			shift: 3'd3, odd: 5'd3, recip: RECIP_3};
		unique case (code)
			RATE_6M:  r = '{1'b1, 3'd0, 2'd0, 8'd24,  3'd3, 5'd3,  RECIP_3};
			RATE_9M:  r = '{1'b1, 3'd1, 2'd0, 8'd36,  3'd2, 5'd9,  RECIP_9};
			RATE_12M: r = '{1'b1, 3'd2, 2'd1, 8'd48,  3'd4, 5'd3,  RECIP_3};
			RATE_18M: r = '{1'b1, 3'd3, 2'd1, 8'd72,  3'd3, 5'd9,  RECIP_9};
			RATE_24M: r = '{1'b1, 3'd4, 2'd2, 8'd96,  3'd5, 5'd3,  RECIP_3};
			RATE_36M: r = '{1'b1, 3'd5, 2'd2, 8'd144, 3'd4, 5'd9,  RECIP_9};
			RATE_48M: r = '{1'b1, 3'd6, 2'd3, 8'd192, 3'd6, 5'd3,  RECIP_3};
			RATE_54M: r = '{1'b1, 3'd7, 2'd3, 8'd216, 3'd3, 5'd27, RECIP_27};
			default:  r.known = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/wsf_decode.sv
// stage 1: parity check, rate decode and ceiling dividend
// depends on wsf_pkg
`default_nettype none
module wsf_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [17:0]       signal_bits,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wsf_pkg::s1_word_t      out_word
);
	wsf_pkg::rate_info_t info;
	wsf_pkg::s1_word_t   word_d;
	wsf_pkg::s1_word_t   word_s1;
	logic                valid_s1;
	logic [11:0]         length;
	logic [15:0]         numer;

	assign length = signal_bits[16:5];
	assign info   = wsf_pkg::rate_lookup(signal_bits[3:0]);
	// ceil(total / per) as floor((total + per - 1) / per)
	assign numer  = wsf_pkg::SERVICE_TAIL_BITS + {1'b0, length, 3'b000}
		+ {8'd0, info.per_symbol} - 16'd1;

	always_comb begin
		word_d          = '0;
		word_d.length   = length;
		word_d.dividend = 14'(numer >> info.shift);
		word_d.odd      = info.odd;
		word_d.recip    = info.recip;
		if ((^signal_bits[16:0]) != signal_bits[17]) begin
			word_d.status = wsf_pkg::ST_PARITY;
		end else if (!info.known) begin
			word_d.status = wsf_pkg::ST_RATE;
		end else begin
			word_d.status     = wsf_pkg::ST_OK;
			word_d.encoding   = info.encoding;
			word_d.modulation = info.modulation;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;
endmodule
`default_nettype wire

### rtl/wsf_recip.sv
// stage 2: quotient estimate by reciprocal multiply
// depends on wsf_pkg
`default_nettype none
module wsf_recip (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wsf_pkg::s1_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wsf_pkg::s2_word_t      out_word
);
	logic [27:0]       prod;
	wsf_pkg::s2_word_t word_s2;
	logic              valid_s2;

	// dividend < 2^14, so the estimate is floor or floor - 1
	assign prod = {14'd0, in_word.dividend} * {13'd0, in_word.recip};

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s2.status     <= in_word.status;
			word_s2.encoding   <= in_word.encoding;
			word_s2.modulation <= in_word.modulation;
			word_s2.length     <= in_word.length;
			word_s2.dividend   <= in_word.dividend;
			word_s2.odd        <= in_word.odd;
			word_s2.quot_est   <= prod[26:16];
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;
endmodule
`default_nettype wire

### rtl/wsf_correct.sv
// stage 3: remainder check, quotient fix-up and result register
// depends on wsf_pkg
`default_nettype none
module wsf_correct (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wsf_pkg::s2_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [2:0]             encoding,
	output logic [1:0]             modulation,
	output logic [11:0]            frame_length_bytes,
	output logic [10:0]            data_symbols
);
	logic [15:0] back;
	logic [15:0] rem;
	logic [10:0] quot;
	logic        valid_s3;
	logic [1:0]  status_s3;
	logic [2:0]  encoding_s3;
	logic [1:0]  modulation_s3;
	logic [11:0] length_s3;
	logic [10:0] symbols_s3;

	assign back = {5'd0, in_word.quot_est} * {11'd0, in_word.odd};
	assign rem  = {2'd0, in_word.dividend} - back;
	assign quot = in_word.quot_est + 11'(rem >= {11'd0, in_word.odd});

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			status_s3     <= in_word.status;
			encoding_s3   <= in_word.encoding;
			modulation_s3 <= in_word.modulation;
			length_s3     <= in_word.length;
			symbols_s3    <= (in_word.status == wsf_pkg::ST_OK) ? quot : 11'd0;
		end
	end

	assign out_valid          = valid_s3;
	assign status             = status_s3;
	assign encoding           = encoding_s3;
	assign modulation         = modulation_s3;
	assign frame_length_bytes = length_s3;
	assign data_symbols       = symbols_s3;
endmodule
`default_nettype wire

### rtl/wifi_signal_field_parser.sv
// top level of the ofdm signal field parser: three pipeline stages
// depends on wsf_pkg, wsf_decode, wsf_recip, wsf_correct
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   header   | sig_valid / sig_ready | signal_bits[17:0]
//   result   | res_valid / res_ready | status, encoding, modulation,
//            |                       | frame_length_bytes, data_symbols
//
// one word accepted per cycle unless a res_ready stall backs up to sig_ready
// each word passes in order through the stages: decode, reciprocal multiply, remainder fix-up
// arst_n clears the stage valid bits only; payload registers are not reset
// each stage holds its word while the next one is full and stalled, so a
// res_ready low backs up through the stages without losing a word
`default_nettype none
module wifi_signal_field_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sig_valid,
	output logic             sig_ready,
	input  wire logic [17:0] signal_bits,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [1:0]       status,
	output logic [2:0]       encoding,
	output logic [1:0]       modulation,
	output logic [11:0]      frame_length_bytes,
	output logic [10:0]      data_symbols
);
	// stage 1 to stage 2
	logic              v1;
	logic              r1;
	wsf_pkg::s1_word_t w1;
	// stage 2 to stage 3
	logic              v2;
	logic              r2;
	wsf_pkg::s2_word_t w2;

	// parity and rate decode, dividend divided by the power of two of the rate
	wsf_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sig_valid),
		.in_ready    (sig_ready),
		.signal_bits (signal_bits),
		.out_valid   (v1),
		.out_ready   (r1),
		.out_word    (w1)
	);

	// divide by the odd factor 3, 9 or 27 through a reciprocal
	wsf_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_word   (w1),
		.out_valid (v2),
		.out_ready (r2),
		.out_word  (w2)
	);

	// fix the estimate up by one where needed, zero data_symbols on error
	wsf_correct u_correct (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (v2),
		.in_ready           (r2),
		.in_word            (w2),
		.out_valid          (res_valid),
		.out_ready          (res_ready),
		.status             (status),
		.encoding           (encoding),
		.modulation         (modulation),
		.frame_length_bytes (frame_length_bytes),
		.data_symbols       (data_symbols)
	);
endmodule
`default_nettype wire

### rtl/wsf_checker.sv
// port-level checks for the signal field parser, bound to the top level
// depends on wsf_pkg and wifi_signal_field_parser
`default_nettype none
module wsf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  status,
	input wire logic [2:0]  encoding,
	input wire logic [1:0]  modulation,
	input wire logic [10:0] data_symbols
);
	// a stalled result stays valid and keeps its status and data_symbols
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status)
			&& $stable(data_symbols))
		else $error("result word changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status == wsf_pkg::ST_OK || status == wsf_pkg::ST_PARITY
			|| status == wsf_pkg::ST_RATE)
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != wsf_pkg::ST_OK |->
			encoding == 3'd0 && modulation == 2'd0 && data_symbols == 11'd0)
		else $error("fields not cleared on error");

	a_symbols_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == wsf_pkg::ST_OK |-> data_symbols != 11'd0)
		else $error("valid frame with no data symbols");

	a_mod_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == wsf_pkg::ST_OK |-> modulation == encoding[2:1])
		else $error("modulation does not match encoding");
endmodule

bind wifi_signal_field_parser wsf_checker u_wsf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.status       (status),
	.encoding     (encoding),
	.modulation   (modulation),
	.data_symbols (data_symbols)
);
`default_nettype wire
